FILE: hdl/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

	localparam int MaxBytes = 6;

	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChSlash  = 8'h2F;
	localparam logic [7:0] ChU      = 8'h75;
	localparam logic [7:0] ChSpace  = 8'h20;

	localparam logic [20:0] CpReplace = 21'h00FFFD;
	localparam logic [20:0] CpPlane1  = 21'h010000;

	typedef enum logic [3:0] {
		PH_WAIT        = 4'd0,
		PH_STR         = 4'd1,
		PH_ESC         = 4'd2,
		PH_HEX1        = 4'd3,
		PH_HIGH        = 4'd4,
		PH_HIGH_ESC    = 4'd5,
		PH_HEX2        = 4'd6,
		PH_DONE        = 4'd7,
		PH_ERR_NOQUOTE = 4'd8,
		PH_ERR_CTRL    = 4'd9,
		PH_ERR_ESC     = 4'd10,
		PH_ERR_HEX     = 4'd11
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUN     = 3'd0,
		ST_DONE    = 3'd1,
		ST_NOQUOTE = 3'd2,
		ST_CTRL    = 3'd3,
		ST_BADESC  = 3'd4,
		ST_BADHEX  = 3'd5,
		ST_SHORT   = 3'd6,
		ST_UNTERM  = 3'd7
	} status_t;

	typedef struct packed {
		logic [MaxBytes-1:0][7:0] data;
		logic [2:0]               count;
		status_t                  status;
	} result_t;

	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      len;
	} utf8_t;

	function automatic utf8_t encode_cp(input logic [20:0] cp);
		utf8_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.len     = 3'd1;
			e.data[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			e.len     = 3'd2;
			e.data[0] = {3'b110, cp[10:6]};
			e.data[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			e.len     = 3'd3;
			e.data[0] = {4'b1110, cp[15:12]};
			e.data[1] = {2'b10, cp[11:6]};
			e.data[2] = {2'b10, cp[5:0]};
		end else begin
			e.len     = 3'd4;
			e.data[0] = {5'b11110, cp[20:18]};
			e.data[1] = {2'b10, cp[17:12]};
			e.data[2] = {2'b10, cp[11:6]};
			e.data[3] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

	function automatic status_t held_status(input phase_t p);
		status_t s;
		case (p)
			PH_DONE:        s = ST_DONE;
			PH_ERR_NOQUOTE: s = ST_NOQUOTE;
			PH_ERR_CTRL:    s = ST_CTRL;
			PH_ERR_ESC:     s = ST_BADESC;
			PH_ERR_HEX:     s = ST_BADHEX;
			default:        s = ST_RUN;
		endcase
		return s;
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] h);
		logic [4:0] r;
		r = '0;
		if (h >= 8'h30 && h <= 8'h39) begin
			r = {1'b1, 4'(h - 8'h30)};
		end else if (h >= 8'h61 && h <= 8'h66) begin
			r = {1'b1, 4'(h - 8'h57)};
		end else if (h >= 8'h41 && h <= 8'h46) begin
			r = {1'b1, 4'(h - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic [8:0] esc_map(input logic [7:0] e);
		logic [8:0] r;
		case (e)
			ChQuote:  r = {1'b1, ChQuote};
			ChBslash: r = {1'b1, ChBslash};
			ChSlash:  r = {1'b1, ChSlash};
			8'h62:    r = {1'b1, 8'h08};
			8'h66:    r = {1'b1, 8'h0C};
			8'h6E:    r = {1'b1, 8'h0A};
			8'h72:    r = {1'b1, 8'h0D};
			8'h74:    r = {1'b1, 8'h09};
			default:  r = '0;
		endcase
		return r;
	endfunction

	function automatic phase_t plain_next(input logic [7:0] c);
		phase_t p;
		if (c == ChQuote) begin
			p = PH_DONE;
		end else if (c < ChSpace) begin
			p = PH_ERR_CTRL;
		end else if (c == ChBslash) begin
			p = PH_ESC;
		end else begin
			p = PH_STR;
		end
		return p;
	endfunction

endpackage

FILE: hdl/jsu_decode.sv
`timescale 1ns / 1ps

module jsu_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              command,
	input  logic [7:0]        data_byte,
	output jsu_pkg::result_t  res
);

	jsu_pkg::phase_t phase_q, phase_d;
	logic [15:0]     accum_q, accum_d;
	logic [1:0]      digits_q, digits_d;
	logic [15:0]     held_q, held_d;

	logic [4:0]  hv;
	logic        hex_ok;
	logic        hex_full;
	logic [15:0] hex_word;
	logic        is_hi;
	logic        is_lo;
	logic [20:0] pair_cp;
	logic [8:0]  em;
	logic        plain_put;

	logic        a_en;
	logic [20:0] a_cp;
	logic        b_en;
	logic        b_raw;
	logic [20:0] b_cp;
	logic [7:0]  b_byte;
	jsu_pkg::utf8_t ea, eb;
	logic [2:0]  la, lb;

	jsu_pkg::status_t                   st_w;
	logic [2:0]                         count_w;
	logic [jsu_pkg::MaxBytes-1:0][7:0]  data_w;

	assign hv        = jsu_pkg::hex_val(data_byte);
	assign hex_ok    = hv[4];
	assign hex_full  = (digits_q == 2'd3);
	assign hex_word  = {accum_q[11:0], hv[3:0]};
	assign is_hi     = (hex_word[15:10] == 6'b110110);
	assign is_lo     = (hex_word[15:10] == 6'b110111);
	assign pair_cp   = jsu_pkg::CpPlane1 + {1'b0, held_q[9:0], hex_word[9:0]};
	assign em        = jsu_pkg::esc_map(data_byte);
	assign plain_put = (jsu_pkg::plain_next(data_byte) == jsu_pkg::PH_STR);

	assign res = {data_w, count_w, st_w};

	always_comb begin
		phase_d  = phase_q;
		accum_d  = accum_q;
		digits_d = digits_q;
		held_d   = held_q;
		if (command) begin
			phase_d  = jsu_pkg::PH_WAIT;
			accum_d  = '0;
			digits_d = '0;
			held_d   = '0;
		end else begin
			unique case (phase_q)
				jsu_pkg::PH_WAIT: begin
					phase_d = (data_byte == jsu_pkg::ChQuote) ? jsu_pkg::PH_STR
						: jsu_pkg::PH_ERR_NOQUOTE;
				end
				jsu_pkg::PH_STR: begin
					phase_d = jsu_pkg::plain_next(data_byte);
				end
				jsu_pkg::PH_ESC: begin
					if (data_byte == jsu_pkg::ChU) begin
						phase_d  = jsu_pkg::PH_HEX1;
						accum_d  = '0;
						digits_d = '0;
					end else begin
						phase_d = em[8] ? jsu_pkg::PH_STR : jsu_pkg::PH_ERR_ESC;
					end
				end
				jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
					if (!hex_ok) begin
						phase_d = jsu_pkg::PH_ERR_HEX;
					end else if (!hex_full) begin
						accum_d  = hex_word;
						digits_d = digits_q + 2'd1;
					end else begin
						accum_d  = '0;
						digits_d = '0;
						if (phase_q == jsu_pkg::PH_HEX1) begin
							if (is_hi) begin
								held_d  = hex_word;
								phase_d = jsu_pkg::PH_HIGH;
							end else begin
								phase_d = jsu_pkg::PH_STR;
							end
						end else if (is_hi) begin
							held_d  = hex_word;
							phase_d = jsu_pkg::PH_HIGH;
						end else begin
							held_d  = '0;
							phase_d = jsu_pkg::PH_STR;
						end
					end
				end
				jsu_pkg::PH_HIGH: begin
					if (data_byte == jsu_pkg::ChBslash) begin
						phase_d = jsu_pkg::PH_HIGH_ESC;
					end else begin
						held_d  = '0;
						phase_d = jsu_pkg::plain_next(data_byte);
					end
				end
				jsu_pkg::PH_HIGH_ESC: begin
					if (data_byte == jsu_pkg::ChU) begin
						phase_d  = jsu_pkg::PH_HEX2;
						accum_d  = '0;
						digits_d = '0;
					end else begin
						held_d  = '0;
						phase_d = em[8] ? jsu_pkg::PH_STR : jsu_pkg::PH_ERR_ESC;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_comb begin
		a_en     = 1'b0;
		a_cp     = '0;
		b_en     = 1'b0;
		b_raw    = 1'b0;
		b_cp     = '0;
		b_byte   = '0;
		st_w     = jsu_pkg::held_status(phase_d);
		if (command) begin
			unique case (phase_q)
				jsu_pkg::PH_WAIT:                    st_w = jsu_pkg::ST_NOQUOTE;
				jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2:  st_w = jsu_pkg::ST_SHORT;
				jsu_pkg::PH_STR, jsu_pkg::PH_ESC,
				jsu_pkg::PH_HIGH, jsu_pkg::PH_HIGH_ESC: st_w = jsu_pkg::ST_UNTERM;
				default:                             st_w = jsu_pkg::held_status(phase_q);
			endcase
		end else begin
			unique case (phase_q)
				jsu_pkg::PH_STR: begin
					b_en   = plain_put;
					b_raw  = 1'b1;
					b_byte = data_byte;
				end
				jsu_pkg::PH_ESC: begin
					b_en   = em[8];
					b_raw  = 1'b1;
					b_byte = em[7:0];
				end
				jsu_pkg::PH_HEX1: begin
					a_en = hex_ok && hex_full && !is_hi;
					a_cp = is_lo ? jsu_pkg::CpReplace : {5'b0, hex_word};
				end
				jsu_pkg::PH_HEX2: begin
					a_en = hex_ok && hex_full;
					a_cp = is_lo ? pair_cp : jsu_pkg::CpReplace;
					b_en = hex_ok && hex_full && !is_lo && !is_hi;
					b_cp = {5'b0, hex_word};
				end
				jsu_pkg::PH_HIGH: begin
					a_en   = (data_byte != jsu_pkg::ChBslash);
					a_cp   = jsu_pkg::CpReplace;
					b_en   = plain_put;
					b_raw  = 1'b1;
					b_byte = data_byte;
				end
				jsu_pkg::PH_HIGH_ESC: begin
					a_en   = (data_byte != jsu_pkg::ChU);
					a_cp   = jsu_pkg::CpReplace;
					b_en   = (data_byte != jsu_pkg::ChU) && em[8];
					b_raw  = 1'b1;
					b_byte = em[7:0];
				end
				default: begin
					a_en = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		logic [2:0] k;
		ea = jsu_pkg::encode_cp(a_cp);
		eb = jsu_pkg::encode_cp(b_cp);
		if (b_raw) begin
			eb      = '0;
			eb.len  = 3'd1;
			eb.data[0] = b_byte;
		end
		la = a_en ? ea.len : 3'd0;
		lb = b_en ? eb.len : 3'd0;
		count_w = la + lb;
		data_w  = '0;
		for (int i = 0; i < jsu_pkg::MaxBytes; i++) begin
			k = 3'(i) - la;
			if (3'(i) < la) begin
				data_w[i] = ea.data[i[1:0]];
			end else if (k < 3'd4) begin
				data_w[i] = eb.data[k[1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= jsu_pkg::PH_WAIT;
			accum_q  <= '0;
			digits_q <= '0;
			held_q   <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			accum_q  <= accum_d;
			digits_q <= digits_d;
			held_q   <= held_d;
		end
	end

endmodule

FILE: hdl/jsu_outbuf.sv
`timescale 1ns / 1ps

module jsu_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  jsu_pkg::result_t  res,
	output logic              busy,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic [2:0]        status,
	output logic              last
);

	jsu_pkg::result_t res_s1;
	logic             valid_s1;
	logic [2:0]       idx_q;
	logic             take;

	assign result_valid = valid_s1;
	assign byte_valid   = (res_s1.count != 3'd0);
	assign out_byte     = byte_valid ? res_s1.data[idx_q] : 8'h00;
	assign status       = res_s1.status;
	assign last         = !byte_valid || (idx_q == res_s1.count - 3'd1);
	assign take         = valid_s1 && !result_stall;
	// free the buffer on the cycle its final word leaves
	assign busy         = valid_s1 && !(take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (take) begin
			if (last) begin
				valid_s1 <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1 <= res;
		end
	end

endmodule

FILE: hdl/json_string_unescape_utf8.sv
`timescale 1ns / 1ps

// Decodes a quoted JSON string literal, one raw byte per accepted word, into
// UTF-8 words with a running status. Each input word is decoded in the cycle it
// is accepted and its 1 to 6 result words are held in one output buffer, which
// sends one word per cycle while result_stall is low; the next input is taken in
// the cycle the previous item's final word leaves, so plain text runs at one byte
// per clock when the output does not stall. A command of 1 marks end of input,
// reports the outcome and rearms the decoder for the next literal.

module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       command,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic [2:0] status,
	output logic       last
);

	jsu_pkg::result_t res;
	logic             accept;

	assign accept = item_valid && !item_stall;

	jsu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.command   (command),
		.data_byte (data_byte),
		.res       (res)
	);

	jsu_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.res          (res),
		.busy         (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.status       (status),
		.last         (last)
	);

endmodule

FILE: hdl/jsu_checker.sv
`timescale 1ns / 1ps

module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic [2:0] status,
	input logic       last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_byte)
			&& $stable(byte_valid) && $stable(status) && $stable(last))
		else $error("stalled result word changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !byte_valid |-> last && out_byte == 8'h00)
		else $error("empty result word is not a lone final word");

	a_same_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last |=>
			result_valid && byte_valid && status == $past(status))
		else $error("item words broken or status changed within an item");

	a_no_take_midway: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> item_stall)
		else $error("input taken while an item still has words to send");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.out_byte     (out_byte),
	.byte_valid   (byte_valid),
	.status       (status),
	.last         (last)
);
